// ----- hw/rtl/wpv_pkg.sv -----
// shared constants and types for the windowed pid velocity step core
`timescale 1ns / 1ps
`default_nettype none
package wpv_pkg;

  localparam int IN_W   = 16;  // measured velocity
  localparam int TGT_W  = 15;  // target velocity
  localparam int GAIN_W = 16;  // q8.8 gains
  localparam int DT_W   = 8;   // derivative divisor
  localparam int ERR_W  = 17;  // signed error
  localparam int OUT_W  = 32;  // drive increment
  localparam int FRAC_W = 8;   // q8.8 fraction bits dropped at the end

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_W  = 3;

  localparam logic [REG_W-1:0] REG_TARGET = 3'd0;
  localparam logic [REG_W-1:0] REG_KP     = 3'd1;
  localparam logic [REG_W-1:0] REG_KI     = 3'd2;
  localparam logic [REG_W-1:0] REG_KD     = 3'd3;
  localparam logic [REG_W-1:0] REG_DT     = 3'd4;

  localparam logic [TGT_W-1:0]  TARGET_RST = 15'd0;
  localparam logic [GAIN_W-1:0] KP_RST     = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RST     = 16'd51;
  localparam logic [GAIN_W-1:0] KD_RST     = 16'd26;
  localparam logic [DT_W-1:0]   DT_RST     = 8'd2;

  typedef logic signed [ERR_W-1:0] err_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wpv_win.sv -----
// error ring with valid bits and running window sum
`timescale 1ns / 1ps
`default_nettype none
module wpv_win #(
  parameter int WINDOW = 20,
  parameter int SUM_W  = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic                    upd_en_i,
  input  wpv_pkg::err_t           err_i,
  output logic signed [SUM_W-1:0] sum_o
);
  import wpv_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);

  err_t                    mem [WINDOW];
  err_t                    rd_q;
  logic                    rd_vld_q;
  logic [WINDOW-1:0]       vld_q;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic signed [SUM_W-1:0] sum_q, sum_d, old_ext;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      mem[idx_q] <= err_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[idx_q];
    end
  end

  assign idx_d   = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
  // never written slots read as zero
  assign old_ext = rd_vld_q ? SUM_W'(rd_q) : '0;
  assign sum_d   = sum_q - old_ext + SUM_W'(err_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[idx_q];
      end
      if (upd_en_i) begin
        vld_q[idx_q] <= 1'b1;
        idx_q        <= idx_d;
        sum_q        <= sum_d;
      end
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

// ----- hw/rtl/wpv_mac.sv -----
// bit-serial multiplier, unsigned gain times signed operand, one gain bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module wpv_mac #(
  parameter int OP_W = 17
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [wpv_pkg::GAIN_W-1:0]             gain_i,
  input  logic signed [OP_W-1:0]                 op_i,
  output logic                                   busy_o,
  output logic signed [OP_W+wpv_pkg::GAIN_W-1:0] prod_o
);
  import wpv_pkg::*;

  localparam int RES_W = OP_W + GAIN_W;
  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [GAIN_W-1:0]       gain_q;
  logic signed [RES_W-1:0] op_q, acc_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q;

  // gain shifts out lsb first, operand shifts up alongside
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gain_q <= gain_i;
      op_q   <= RES_W'(op_i);
      acc_q  <= '0;
    end else if (busy_q) begin
      if (gain_q[0]) begin
        acc_q <= acc_q + op_q;
      end
      gain_q <= gain_q >> 1;
      op_q   <= op_q <<< 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(GAIN_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// ----- hw/rtl/wpv_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module wpv_div #(
  parameter int NUM_W = 33
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [wpv_pkg::DT_W-1:0]     den_i,
  output logic                         busy_o,
  output logic [NUM_W-1:0]             quo_o
);
  import wpv_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DT_W-1:0]  rem_q, den_q;
  logic [DT_W:0]    trial;
  logic             fits;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DT_W'(trial - {1'b0, den_q}) : trial[DT_W-1:0];
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(NUM_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;

endmodule
`default_nettype wire

// ----- hw/rtl/windowed_pid_velocity_step_core.sv -----
// top level: config registers, sequencer, serial pid datapath and output register
// one item at a time: a new input is accepted only in idle, after the previous item has run
//   the 16-step serial multiply and the 33-step serial divide of the derivative term
// a finished result waits in the output register while the next item is accepted
// reset: async active low, clears the error ring (valid bits), sum, previous
//   error and restores the gain, target and divisor registers to their defaults
`timescale 1ns / 1ps
`default_nettype none
module windowed_pid_velocity_step_core #(
  parameter int WINDOW = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // [15:0] measured_velocity
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [31:0] drive_increment
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wpv_pkg::APB_AW-1:0] paddr,
  input  logic [wpv_pkg::APB_DW-1:0] pwdata,
  output logic [wpv_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import wpv_pkg::*;

  // widths that follow from the window depth
  localparam int SUM_W = ERR_W + $clog2(WINDOW);   // window sum
  localparam int DIF_W = ERR_W + 1;                // error difference
  localparam int PK_W  = SUM_W + GAIN_W + 1;       // kp*e + ki*sum
  localparam int D_W   = DIF_W + GAIN_W;           // kd*diff
  localparam int MAG_W = D_W - 1;                  // |kd*diff|
  localparam int TOT_W = PK_W + 1;                 // full sum of terms
  localparam int SH_W  = TOT_W - FRAC_W;           // after the q8.8 shift

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;  // ring slot overwritten, window sum updated
  localparam logic [2:0] ST_LOAD   = 3'd2;  // start the multipliers
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;  // start the divider
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_q, state_d;

  // config registers
  logic [TGT_W-1:0]  target_q;
  logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [DT_W-1:0]   dt_q;
  logic              cfg_wr;
  logic [REG_W-1:0]  reg_idx;

  // datapath
  err_t                    err_d, err_q, prev_q;
  logic signed [DIF_W-1:0] dif_q;
  logic signed [SUM_W-1:0] win_sum;
  logic signed [ERR_W+GAIN_W-1:0] kp_prod;
  logic signed [SUM_W+GAIN_W-1:0] ki_prod;
  logic signed [D_W-1:0]   kd_prod, kd_neg;
  logic                    kp_busy, ki_busy, kd_busy, div_busy;
  logic                    in_acc;
  logic                    mac_start, div_start;
  logic [MAG_W-1:0]        kd_mag, quo;
  logic [DT_W-1:0]         den;
  logic signed [PK_W-1:0]  pk_q;
  logic signed [TOT_W-1:0] d_ext, d_val, total;
  logic signed [SH_W-1:0]  shifted;
  logic [SH_W-OUT_W:0]     hi_bits;
  logic [OUT_W-1:0]        res, out_q;
  logic                    out_vld_q, out_load;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      kp_q     <= KP_RST;
      ki_q     <= KI_RST;
      kd_q     <= KD_RST;
      dt_q     <= DT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TARGET: target_q <= pwdata[TGT_W-1:0];
        REG_KP:     kp_q     <= pwdata[GAIN_W-1:0];
        REG_KI:     ki_q     <= pwdata[GAIN_W-1:0];
        REG_KD:     kd_q     <= pwdata[GAIN_W-1:0];
        REG_DT:     dt_q     <= pwdata[DT_W-1:0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET: prdata = APB_DW'(target_q);
      REG_KP:     prdata = APB_DW'(kp_q);
      REG_KI:     prdata = APB_DW'(ki_q);
      REG_KD:     prdata = APB_DW'(kd_q);
      REG_DT:     prdata = APB_DW'(dt_q);
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- sequencer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mac_start     = (state_q == ST_LOAD);
  assign div_start     = (state_q == ST_DSTART);
  // result leaves only when the output register is free or being drained
  assign out_load      = (state_q == ST_OUT) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_READ;
      ST_READ:   state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_MUL;
      ST_MUL:    if (!kp_busy) state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DIV;
      ST_DIV:    if (!div_busy) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------- error and delta
  // error = target - measurement, both zero-extended into 17 bits
  assign err_d = $signed({2'b00, target_q}) - $signed({1'b0, s_axis_tdata});

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q <= err_d;
      dif_q <= DIF_W'(err_d) - DIF_W'(prev_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (in_acc) begin
      prev_q <= err_d;
    end
  end

  // ring read at accept, slot overwrite and sum update in the following cycle (ST_READ)
  wpv_win #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc),
    .upd_en_i (state_q == ST_READ),
    .err_i    (err_q),
    .sum_o    (win_sum)
  );

  // ------------------------------------------------------ serial multiplies
  wpv_mac #(.OP_W(ERR_W)) u_mac_kp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .gain_i  (kp_q),
    .op_i    (err_q),
    .busy_o  (kp_busy),
    .prod_o  (kp_prod)
  );

  wpv_mac #(.OP_W(SUM_W)) u_mac_ki (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .gain_i  (ki_q),
    .op_i    (win_sum),
    .busy_o  (ki_busy),
    .prod_o  (ki_prod)
  );

  wpv_mac #(.OP_W(DIF_W)) u_mac_kd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .gain_i  (kd_q),
    .op_i    (dif_q),
    .busy_o  (kd_busy),
    .prod_o  (kd_prod)
  );

  // p and i terms combined while the divider starts
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      pk_q <= PK_W'(kp_prod) + PK_W'(ki_prod);
    end
  end

  // ------------------------------------------------------ derivative divide
  // divide the magnitude, reapply the sign: truncation toward zero
  assign kd_neg = -kd_prod;
  assign kd_mag = kd_prod[D_W-1] ? kd_neg[MAG_W-1:0] : kd_prod[MAG_W-1:0];
  // a zero divisor acts as one
  assign den    = (dt_q == '0) ? DT_W'(1) : dt_q;

  wpv_div #(.NUM_W(MAG_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (kd_mag),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // ----------------------------------------------------- sum, shift, clamp
  assign d_ext   = TOT_W'($signed({1'b0, quo}));
  assign d_val   = kd_prod[D_W-1] ? -d_ext : d_ext;
  assign total   = TOT_W'(pk_q) + d_val;
  // arithmetic shift rounds toward minus infinity
  assign shifted = total[TOT_W-1:FRAC_W];
  assign hi_bits = shifted[SH_W-1:OUT_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      res = shifted[OUT_W-1:0];
    end else if (shifted[SH_W-1]) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ------------------------------------------------------------ assertions
  a_acc_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_READ))
    else $error("accepted transaction did not start the ring read");

  a_mac_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kp_busy == ki_busy) && (ki_busy == kd_busy))
    else $error("serial multipliers out of step");

  a_mac_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kp_busy |-> (state_q == ST_MUL))
    else $error("multiplier busy outside multiply phase");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide phase");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("output transaction raised without a finished item");

endmodule
`default_nettype wire
